### src/i2cm_pkg.sv
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

    localparam int CmdW = 3;
    localparam int TickW = 16;
    localparam int AddrW = 3;
    localparam int DataW = 32;

    localparam logic [CmdW-1:0] CMD_NONE  = 3'd0;
    localparam logic [CmdW-1:0] CMD_START = 3'd1;
    localparam logic [CmdW-1:0] CMD_STOP  = 3'd2;
    localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
    localparam logic [CmdW-1:0] CMD_READ  = 3'd4;

    localparam logic [TickW-1:0] HALF_BIT_RESET = 16'd100;

    // register index decoded from the word address bit
    localparam logic REG_HALF_BIT = 1'b0;

    typedef enum logic [14:0] {
        PH_IDLE     = 15'b000000000000001,
        PH_ST_CHECK = 15'b000000000000010,
        PH_ST_CLK   = 15'b000000000000100,
        PH_SP_WAIT  = 15'b000000000001000,
        PH_SP_END   = 15'b000000000010000,
        PH_WR_HIGH  = 15'b000000000100000,
        PH_WR_LOW   = 15'b000000001000000,
        PH_WR_AHIGH = 15'b000000010000000,
        PH_WR_ASAMP = 15'b000000100000000,
        PH_WR_END   = 15'b000001000000000,
        PH_RD_HIGH  = 15'b000010000000000,
        PH_RD_SAMP  = 15'b000100000000000,
        PH_RD_AHIGH = 15'b001000000000000,
        PH_RD_ALOW  = 15'b010000000000000,
        PH_RD_END   = 15'b100000000000000
    } t_phase;

    typedef struct packed {
        logic [CmdW-1:0] command;
        logic [7:0]      write_byte;
        logic            send_ack;
        logic            sda_level;
        logic            scl_level;
    } t_item;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] read_byte;
    } t_result;

endpackage

### src/i2cm_engine.sv
// line timing state machine, advanced by one tick per step
module i2cm_engine import i2cm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_item            i_item,
    input  logic [TickW-1:0] i_half_bit_ticks,
    output t_result          o_result
);

    t_phase           r_phase, n_phase;
    logic [TickW-1:0] r_delay, n_delay;
    logic [3:0]       r_bit_idx, n_bit_idx;
    logic [7:0]       r_shift, n_shift;
    logic             r_ack_choice, n_ack_choice;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic             r_flag, n_flag;
    logic [7:0]       r_last_read, n_last_read;

    logic [TickW-1:0] wait_ticks;
    logic [TickW-1:0] dec_delay;
    logic             done;

    always_comb begin
        n_phase      = r_phase;
        n_delay      = r_delay;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_flag       = r_flag;
        n_last_read  = r_last_read;
        done         = 1'b0;
        wait_ticks   = (i_half_bit_ticks == '0) ? TickW'(1) : i_half_bit_ticks;
        dec_delay    = (r_delay != '0) ? r_delay - TickW'(1) : '0;
        if (i_step) begin
            if (r_phase == PH_IDLE) begin
                case (i_item.command)
                    CMD_START: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_delay = wait_ticks;
                        n_phase = PH_ST_CHECK;
                    end
                    CMD_STOP: begin
                        n_sda   = 1'b0;
                        n_scl   = 1'b1;
                        n_delay = wait_ticks;
                        n_phase = PH_SP_WAIT;
                    end
                    CMD_WRITE: begin
                        n_shift   = i_item.write_byte;
                        n_bit_idx = '0;
                        n_sda     = i_item.write_byte[7];
                        n_delay   = wait_ticks;
                        n_phase   = PH_WR_HIGH;
                    end
                    CMD_READ: begin
                        n_shift      = '0;
                        n_bit_idx    = '0;
                        n_ack_choice = i_item.send_ack;
                        n_sda        = 1'b1;
                        n_scl        = 1'b0;
                        n_delay      = wait_ticks;
                        n_phase      = PH_RD_HIGH;
                    end
                    CMD_NONE: ;
                    default: ;
                endcase
            end else begin
                n_delay = dec_delay;
                if (dec_delay == '0) begin
                    case (r_phase)
                        PH_ST_CHECK: begin
                            if (!i_item.sda_level) begin
                                n_flag  = 1'b0;
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_sda   = 1'b0;
                                n_delay = wait_ticks;
                                n_phase = PH_ST_CLK;
                            end
                        end
                        PH_ST_CLK: begin
                            n_scl   = 1'b0;
                            n_flag  = 1'b1;
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_SP_WAIT: begin
                            // target stretching scl, keep checking every tick
                            if (i_item.scl_level) begin
                                n_sda   = 1'b1;
                                n_delay = wait_ticks;
                                n_phase = PH_SP_END;
                            end
                        end
                        PH_SP_END: begin
                            n_flag  = 1'b1;
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_WR_HIGH: begin
                            n_scl   = 1'b1;
                            n_delay = wait_ticks;
                            n_phase = PH_WR_LOW;
                        end
                        PH_WR_LOW: begin
                            n_shift   = {r_shift[6:0], 1'b0};
                            n_bit_idx = r_bit_idx + 4'd1;
                            n_scl     = 1'b0;
                            n_delay   = wait_ticks;
                            if (n_bit_idx < 4'd8) begin
                                n_sda   = r_shift[6];
                                n_phase = PH_WR_HIGH;
                            end else begin
                                n_sda   = 1'b1;
                                n_phase = PH_WR_AHIGH;
                            end
                        end
                        PH_WR_AHIGH: begin
                            n_scl   = 1'b1;
                            n_delay = wait_ticks;
                            n_phase = PH_WR_ASAMP;
                        end
                        PH_WR_ASAMP: begin
                            n_flag  = !i_item.sda_level;
                            n_scl   = 1'b0;
                            n_delay = wait_ticks;
                            n_phase = PH_WR_END;
                        end
                        PH_RD_HIGH: begin
                            n_scl   = 1'b1;
                            n_delay = wait_ticks;
                            n_phase = PH_RD_SAMP;
                        end
                        PH_RD_SAMP: begin
                            n_shift   = {r_shift[6:0], i_item.sda_level};
                            n_bit_idx = r_bit_idx + 4'd1;
                            n_scl     = 1'b0;
                            n_delay   = wait_ticks;
                            if (n_bit_idx < 4'd8) begin
                                n_phase = PH_RD_HIGH;
                            end else begin
                                n_sda   = !r_ack_choice;
                                n_phase = PH_RD_AHIGH;
                            end
                        end
                        PH_RD_AHIGH: begin
                            n_scl   = 1'b1;
                            n_delay = wait_ticks;
                            n_phase = PH_RD_ALOW;
                        end
                        PH_RD_ALOW: begin
                            n_scl   = 1'b0;
                            n_delay = wait_ticks;
                            n_phase = PH_RD_END;
                        end
                        PH_RD_END: begin
                            n_sda       = 1'b1;
                            n_last_read = r_shift;
                            n_flag      = 1'b1;
                            n_phase     = PH_IDLE;
                            done        = 1'b1;
                        end
                        default: begin
                            // write end and any other phase just finish
                            n_phase = PH_IDLE;
                            n_delay = '0;
                            done    = 1'b1;
                        end
                    endcase
                    if (done) begin
                        n_delay = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_delay      <= '0;
            r_bit_idx    <= '0;
            r_shift      <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_flag       <= 1'b0;
            r_last_read  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_delay      <= n_delay;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_flag       <= n_flag;
            r_last_read  <= n_last_read;
        end
    end

    always_comb begin
        o_result.scl_release = n_scl;
        o_result.sda_release = n_sda;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.success     = n_flag;
        o_result.read_byte   = n_last_read;
    end

endmodule

### src/i2cm_out_buf.sv
// two-entry result buffer: output register plus skid register
module i2cm_out_buf import i2cm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_head_valid, r_skid_valid;
    t_result r_head, r_skid;
    logic    pop;

    assign pop     = r_head_valid && i_ready;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_head_valid) begin
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_head_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_head_valid) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

### src/i2c_master_byte_engine.sv
// top level of the i2c master byte engine: input register, engine, result buffer, apb register
// Each accepted input transaction is one line tick and produces exactly one result
// transaction. The engine takes a tick every clock cycle while the output buffer is not full;
// the tick is held in the input register, then the state machine writes its result into the
// output register, or into the skid register while the output register holds an untaken
// result. The two-entry buffer lets ticks keep flowing while a result waits to be taken.
// half_bit_ticks (APB addresses 0 to 3, reset 100) sets how many ticks each SCL half period
// lasts; zero acts as one. Change it only while idle.
module i2c_master_byte_engine import i2cm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CmdW-1:0]  i_command,
    input  logic [7:0]       i_write_byte,
    input  logic             i_send_ack,
    input  logic             i_sda_level,
    input  logic             i_scl_level,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_scl_release,
    output logic             o_sda_release,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic             o_success,
    output logic [7:0]       o_read_byte,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    logic             r_in_valid;
    t_item            r_item;
    logic [TickW-1:0] r_half_bit;
    logic             buf_full;
    logic             step;
    t_result          step_result;
    t_result          out_data;
    logic             reg_hit;

    assign step       = r_in_valid && !buf_full;
    assign o_in_ready = !r_in_valid || !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.command    <= i_command;
            r_item.write_byte <= i_write_byte;
            r_item.send_ack   <= i_send_ack;
            r_item.sda_level  <= i_sda_level;
            r_item.scl_level  <= i_scl_level;
        end
    end

    // apb register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[AddrW-1] == REG_HALF_BIT);
    assign prdata  = reg_hit ? {{(DataW-TickW){1'b0}}, r_half_bit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit <= HALF_BIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_half_bit <= pwdata[TickW-1:0];
        end
    end

    i2cm_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_item           (r_item),
        .i_half_bit_ticks (r_half_bit),
        .o_result         (step_result)
    );

    i2cm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (step_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_scl_release = out_data.scl_release;
    assign o_sda_release = out_data.sda_release;
    assign o_busy_res    = out_data.busy_res;
    assign o_done_res    = out_data.done_res;
    assign o_success     = out_data.success;
    assign o_read_byte   = out_data.read_byte;

endmodule
